/* design/swfe_pkg.sv */
// shared types and constants for the sync word frame extractor
`timescale 1ns / 1ps
`default_nettype none

package swfe_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER  = 2'd0,
    CFG_TRAILER = 2'd1,
    CFG_MAX_LEN = 2'd2
  } cfg_idx_t;

  localparam logic [31:0] HEADER_RESET  = 32'h0116_7b28;
  localparam logic [31:0] TRAILER_RESET = 32'h297d_7e04;
  localparam logic [7:0]  MAX_LEN_RESET = 8'd253;
  localparam logic [7:0]  COUNT_MAX     = 8'hff;

  typedef struct packed {
    logic [31:0] header_pattern;
    logic [31:0] trailer_pattern;
    logic [7:0]  max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic       closed_by_limit;
    logic [7:0] frame_length;
    logic       frame_last;
    logic [7:0] payload_byte;
  } res_t;

endpackage

`default_nettype wire

/* design/swfe_cfg.sv */
// configuration register bank
`timescale 1ns / 1ps
`default_nettype none

module swfe_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  input  wire logic [swfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [swfe_pkg::CFG_DATA_W-1:0]    cfg_data,
  output swfe_pkg::cfg_t                          cfg
);
  import swfe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_pattern  <= HEADER_RESET;
      cfg.trailer_pattern <= TRAILER_RESET;
      cfg.max_frame_bytes <= MAX_LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HEADER:  cfg.header_pattern  <= cfg_data[31:0];
        CFG_TRAILER: cfg.trailer_pattern <= cfg_data[31:0];
        CFG_MAX_LEN: cfg.max_frame_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/swfe_core.sv */
// hunt and frame state with the per-word framing logic
`timescale 1ns / 1ps
`default_nettype none

module swfe_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire swfe_pkg::cfg_t  cfg,
  input  wire logic            accept,
  input  wire logic [7:0]      rx_byte,
  output logic                 res_valid,
  output swfe_pkg::res_t       res,
  output logic [7:0]           byte_count
);
  import swfe_pkg::*;

  logic [31:0] header_shift;
  logic [31:0] trailer_shift;
  logic [31:0] trailer_next;
  logic [7:0]  count_next;
  logic        hunting;
  logic        by_trailer;
  logic        by_limit;
  logic        last;

  always_comb begin
    hunting      = (header_shift != cfg.header_pattern);
    trailer_next = {trailer_shift[23:0], rx_byte};
    count_next   = (byte_count != COUNT_MAX) ? byte_count + 8'd1 : byte_count;
    by_trailer   = (trailer_next == cfg.trailer_pattern);
    by_limit     = (count_next >= cfg.max_frame_bytes);
    last         = by_trailer || by_limit;

    res_valid           = !hunting;
    res.payload_byte    = rx_byte;
    res.frame_last      = last;
    res.frame_length    = count_next;
    res.closed_by_limit = last && !by_trailer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_shift  <= '0;
      trailer_shift <= '0;
      byte_count    <= '0;
    end else if (accept) begin
      if (hunting) begin
        header_shift <= {header_shift[23:0], rx_byte};
      end else if (last) begin
        header_shift  <= {24'd0, rx_byte};
        trailer_shift <= '0;
        byte_count    <= '0;
      end else begin
        trailer_shift <= trailer_next;
        byte_count    <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

/* design/swfe_out.sv */
// output register with flow control back to the input side
`timescale 1ns / 1ps
`default_nettype none

module swfe_out (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            res_valid,
  input  wire swfe_pkg::res_t  res,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [15:0]          m_tdata,
  output logic                 m_tlast,
  output logic                 m_tuser
);
  import swfe_pkg::*;

  res_t held;
  logic load;

  assign in_ready = !m_tvalid || m_tready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {held.frame_length, held.payload_byte};
  assign m_tlast = held.frame_last;
  assign m_tuser = held.closed_by_limit;

endmodule

`default_nettype wire

/* design/sync_word_frame_extractor.sv */
// top level of the sync word frame extractor
// usage:
//   s_* takes one received byte per word in s_tdata[7:0]
//   while hunting, bytes are matched against the header pattern and dropped
//   after a header match, each byte leaves on m_* as payload:
//     m_tdata = {frame_length, payload_byte}, m_tlast closes the frame,
//     m_tuser says the close came from the length limit, not the trailer
//   cfg_* writes header pattern (0), trailer pattern (1), max frame bytes (2);
//     cfg_ready is always high, writes are meant for idle periods
//   a payload word shows on m_* in the cycle after it is taken
//   throughput: one byte per cycle while m_tready is high, set by the single output register
//   when m_tready is low the output word holds and s_tready drops once
//     that register is full
//   rst restores the reset patterns and the limit and starts hunting
//     with cleared shift registers and count
`timescale 1ns / 1ps
`default_nettype none

module sync_word_frame_extractor (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,   // rx_byte
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [15:0]                           m_tdata,   // frame_length, payload_byte
  output logic                                  m_tlast,
  output logic                                  m_tuser,   // closed_by_limit
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [swfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [swfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import swfe_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       res_valid;
  logic       accept;
  logic [7:0] byte_count;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  swfe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swfe_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .rx_byte    (s_tdata),
    .res_valid  (res_valid),
    .res        (res),
    .byte_count (byte_count)
  );

  swfe_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .res_valid (res_valid),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

`ifndef SYNTH
  a_limit_implies_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("limit close without last");

  a_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:8] != 8'd0)
    else $error("payload word with zero length");

  a_close_clears_count: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && res.frame_last |=> byte_count == 8'd0)
    else $error("count not cleared after frame close");

  a_hunt_no_output: assert property (@(posedge clk) disable iff (rst)
    accept && !res_valid |=> !m_tvalid)
    else $error("output word while hunting");
`endif

endmodule

`default_nettype wire
